FILE: hdl/bfa_pkg.sv
// Shared constants and codes for the bitmap frame allocator.
// Holds map geometry, field widths, request, status and register codes.
// No dependencies.
package bfa_pkg;

	// pool capacity in frames, a power of two from 8 to 65536
	localparam int MAX_FRAMES = 1024;

	// field widths
	localparam int FRAME_W = 20;
	localparam int TOTAL_W = 11;
	localparam int COUNT_W = 11;

	// map geometry: OFF_W bits of frame offset, split into word index and bit index
	localparam int OFF_W   = $clog2(MAX_FRAMES);
	localparam int POOL_W  = $clog2(MAX_FRAMES + 1);
	localparam int BIT_W   = (OFF_W - 1 < 5) ? OFF_W - 1 : 5;
	localparam int WORD_W  = 2 ** BIT_W;
	localparam int WIDX_W  = OFF_W - BIT_W;
	localparam int WORDS   = 2 ** WIDX_W;
	localparam int CMP_W   = (TOTAL_W > POOL_W) ? TOTAL_W : POOL_W;

	// stream packing
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_MARK    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_OUTSIDE = 2'd2,
		STAT_RSVD    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 1'd0,
		CFG_TOTAL = 1'd1
	} cfg_idx_t;

endpackage

FILE: hdl/bitmap_frame_allocator.sv
// Bitmap frame allocator top level: used map in a word-wide synchronous memory.
// Depends on bfa_pkg.
//
// Keeps one used bit per frame, WORD_W (32) frames per memory word, one result
// item per request item. An allocate scans the map one word per cycle from the
// bottom through a registered read and runs until a free bit is found or the
// last pool word is checked. A release is a read-modify-write of one word; a
// frame outside the pool ends it without a memory access. A range mark reads
// and rewrites each word that the run touches.
// The map memory has a single read and a single write port.
// The map reads as all free after reset through per-word valid bits, so no
// clearing pass is needed. A new item is taken while the last result still
// waits on the output; config writes are always taken and must only come
// while the block is idle.
module bitmap_frame_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bfa_pkg::S_DATA_W-1:0]    s_tdata,   // [19:0] frame_number, [30:20] frame_count
	input  logic [1:0]                      s_tuser,   // [1:0] req_type
	// result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bfa_pkg::M_DATA_W-1:0]    m_tdata,   // [19:0] frame_out
	output logic [1:0]                      m_tuser,   // [1:0] status
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfa_pkg::FRAME_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_ALLOC,
		ST_REL_RD,
		ST_REL_WR,
		ST_MARK_SET,
		ST_MARK_GO,
		ST_MARK,
		ST_POST
	} state_t;

	state_t state_q;

	// config registers
	logic [bfa_pkg::FRAME_W-1:0] base_q;
	logic [bfa_pkg::TOTAL_W-1:0] total_q;

	// request payload
	bfa_pkg::req_t                req_q;
	logic [bfa_pkg::FRAME_W-1:0]  fnum_q;
	logic [bfa_pkg::COUNT_W-1:0]  count_q;
	logic [bfa_pkg::FRAME_W-1:0]  off_q;

	// scan pointers
	logic [bfa_pkg::WIDX_W-1:0]   scan_q;
	logic [bfa_pkg::WIDX_W-1:0]   chk_w_q;
	logic                         chk_en_q;
	logic [bfa_pkg::OFF_W-1:0]    found_q;

	// range of a mark request, in pool offsets
	logic [bfa_pkg::OFF_W-1:0]    lo_q;
	logic [bfa_pkg::POOL_W-1:0]   hi_q;
	logic [bfa_pkg::OFF_W-1:0]    hl_q;
	logic                         mark_any_q;

	// pending result
	bfa_pkg::status_t             res_status_q;
	logic                         res_alloc_q;

	// map memory and per-word valid bits
	logic [bfa_pkg::WORD_W-1:0]   map_mem [bfa_pkg::WORDS];
	logic [bfa_pkg::WORDS-1:0]    word_vld_q;
	logic [bfa_pkg::WORD_W-1:0]   rd_data_s1;
	logic                         rd_vld_s1;

	logic                         rd_en;
	logic [bfa_pkg::WIDX_W-1:0]   rd_addr;
	logic                         wr_en;
	logic [bfa_pkg::WIDX_W-1:0]   wr_addr;
	logic [bfa_pkg::WORD_W-1:0]   wr_data;

	logic [bfa_pkg::WORD_W-1:0]   cur_word;
	logic [bfa_pkg::POOL_W-1:0]   pool_n;
	logic [bfa_pkg::CMP_W-1:0]    total_ext;
	logic [bfa_pkg::POOL_W-1:0]   pool_m1;
	logic [bfa_pkg::WIDX_W-1:0]   last_w;
	logic [bfa_pkg::BIT_W-1:0]    last_b;
	logic [bfa_pkg::WORD_W-1:0]   alloc_mask;
	logic [bfa_pkg::WORD_W-1:0]   free_bits;
	logic [bfa_pkg::BIT_W-1:0]    free_idx;
	logic                         found;
	logic [bfa_pkg::WORD_W-1:0]   range_mask;
	logic                         in_pool;
	logic [bfa_pkg::FRAME_W:0]    end_w;
	logic [bfa_pkg::FRAME_W:0]    pool_w;
	logic                         fin;
	bfa_pkg::status_t             fin_status;
	logic                         fin_alloc;
	logic                         out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;

	// pool size is min(frame_total, MAX_FRAMES)
	always_comb begin
		total_ext = bfa_pkg::CMP_W'(total_q);
		if (total_ext > bfa_pkg::CMP_W'(bfa_pkg::MAX_FRAMES))
			pool_n = bfa_pkg::POOL_W'(bfa_pkg::MAX_FRAMES);
		else
			pool_n = bfa_pkg::POOL_W'(total_ext);
		pool_m1 = pool_n - bfa_pkg::POOL_W'(1);
		last_w  = pool_m1[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W];
		last_b  = pool_m1[bfa_pkg::BIT_W-1:0];
		in_pool = off_q < bfa_pkg::FRAME_W'(pool_n);
		end_w   = {1'b0, off_q} + (bfa_pkg::FRAME_W+1)'(count_q);
		pool_w  = (bfa_pkg::FRAME_W+1)'(pool_n);
	end

	// word under check; a word never written reads as all free
	assign cur_word = rd_vld_s1 ? rd_data_s1 : '0;

	// first-fit search inside the checked word
	always_comb begin
		for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
			alloc_mask[b] = (chk_w_q < last_w) ||
				((chk_w_q == last_w) && (bfa_pkg::BIT_W'(b) <= last_b));
		end
		free_bits = ~cur_word & alloc_mask;
		found     = |free_bits;
		free_idx  = '0;
		for (int b = bfa_pkg::WORD_W - 1; b >= 0; b--) begin
			if (free_bits[b])
				free_idx = bfa_pkg::BIT_W'(b);
		end
	end

	// bits of the checked word that fall in [lo, hl]
	always_comb begin
		for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
			range_mask[b] =
				((chk_w_q > lo_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W]) ||
				 ((chk_w_q == lo_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W]) &&
				  (bfa_pkg::BIT_W'(b) >= lo_q[bfa_pkg::BIT_W-1:0]))) &&
				((chk_w_q < hl_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W]) ||
				 ((chk_w_q == hl_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W]) &&
				  (bfa_pkg::BIT_W'(b) <= hl_q[bfa_pkg::BIT_W-1:0])));
		end
	end

	// memory access and completion decode per state
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = scan_q;
		wr_en      = 1'b0;
		wr_addr    = chk_w_q;
		wr_data    = cur_word;
		fin        = 1'b0;
		fin_status = bfa_pkg::STAT_OK;
		fin_alloc  = 1'b0;
		case (state_q)
			ST_PREP: begin
				case (req_q)
					bfa_pkg::REQ_ALLOC: begin
						if (pool_n == '0) begin
							fin        = 1'b1;
							fin_status = bfa_pkg::STAT_FULL;
						end
					end
					bfa_pkg::REQ_RELEASE: ;
					bfa_pkg::REQ_MARK: ;
					default: fin = 1'b1;
				endcase
			end
			ST_ALLOC: begin
				rd_en = 1'b1;
				if (chk_en_q) begin
					if (found) begin
						wr_en     = 1'b1;
						wr_data   = cur_word | (bfa_pkg::WORD_W'(1) << free_idx);
						fin       = 1'b1;
						fin_alloc = 1'b1;
					end else if (chk_w_q == last_w) begin
						fin        = 1'b1;
						fin_status = bfa_pkg::STAT_FULL;
					end
				end
			end
			ST_REL_RD: begin
				rd_addr = off_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W];
				if (in_pool) begin
					rd_en = 1'b1;
				end else begin
					fin        = 1'b1;
					fin_status = bfa_pkg::STAT_OUTSIDE;
				end
			end
			ST_REL_WR: begin
				wr_en   = 1'b1;
				wr_addr = off_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W];
				wr_data = cur_word &
					~(bfa_pkg::WORD_W'(1) << off_q[bfa_pkg::BIT_W-1:0]);
				fin     = 1'b1;
			end
			ST_MARK_GO: begin
				if (!mark_any_q || (bfa_pkg::POOL_W'(lo_q) >= hi_q))
					fin = 1'b1;
			end
			ST_MARK: begin
				rd_en = 1'b1;
				if (chk_en_q) begin
					wr_en   = 1'b1;
					wr_data = cur_word | range_mask;
					if (chk_w_q == hl_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W])
						fin = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// map memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en)
			map_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= map_mem[rd_addr];
	end

	// per-word valid bits: reset marks the whole map free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (wr_en)
				word_vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_s1 <= word_vld_q[rd_addr];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			total_q <= bfa_pkg::TOTAL_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bfa_pkg::CFG_BASE:  base_q  <= cfg_data;
				bfa_pkg::CFG_TOTAL: total_q <= cfg_data[bfa_pkg::TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q   <= bfa_pkg::req_t'(s_tuser);
			fnum_q  <= s_tdata[bfa_pkg::FRAME_W-1:0];
			count_q <= s_tdata[bfa_pkg::FRAME_W+bfa_pkg::COUNT_W-1:bfa_pkg::FRAME_W];
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_alloc_q  <= fin_alloc;
		end
		case (state_q)
			ST_PREP: begin
				off_q  <= fnum_q - base_q;
				scan_q <= '0;
			end
			ST_ALLOC: begin
				scan_q  <= scan_q + 1'b1;
				chk_w_q <= scan_q;
				if (chk_en_q && found)
					found_q <= {chk_w_q, free_idx};
			end
			ST_MARK_SET: begin
				// clip the run to the pool; it can wrap into the pool from the top
				if (in_pool) begin
					lo_q       <= off_q[bfa_pkg::OFF_W-1:0];
					hi_q       <= (end_w < pool_w) ? bfa_pkg::POOL_W'(end_w) : pool_n;
					mark_any_q <= 1'b1;
				end else if (end_w[bfa_pkg::FRAME_W]) begin
					lo_q       <= '0;
					hi_q       <= ({1'b0, end_w[bfa_pkg::FRAME_W-1:0]} < pool_w) ?
						bfa_pkg::POOL_W'(end_w[bfa_pkg::FRAME_W-1:0]) : pool_n;
					mark_any_q <= 1'b1;
				end else begin
					mark_any_q <= 1'b0;
				end
			end
			ST_MARK_GO: begin
				hl_q   <= bfa_pkg::OFF_W'(hi_q - bfa_pkg::POOL_W'(1));
				scan_q <= lo_q[bfa_pkg::OFF_W-1:bfa_pkg::BIT_W];
			end
			ST_MARK: begin
				scan_q  <= scan_q + 1'b1;
				chk_w_q <= scan_q;
			end
			default: ;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chk_en_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else begin
			// the post state reloads the output itself
			if (m_tready && (state_q != ST_POST))
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					chk_en_q <= 1'b0;
					if (fin)
						state_q <= ST_POST;
					else if (req_q == bfa_pkg::REQ_ALLOC)
						state_q <= ST_ALLOC;
					else if (req_q == bfa_pkg::REQ_RELEASE)
						state_q <= ST_REL_RD;
					else
						state_q <= ST_MARK_SET;
				end
				ST_ALLOC: begin
					chk_en_q <= 1'b1;
					if (fin)
						state_q <= ST_POST;
				end
				ST_REL_RD: begin
					state_q <= fin ? ST_POST : ST_REL_WR;
				end
				ST_REL_WR: begin
					state_q <= ST_POST;
				end
				ST_MARK_SET: begin
					state_q <= ST_MARK_GO;
				end
				ST_MARK_GO: begin
					chk_en_q <= 1'b0;
					state_q  <= fin ? ST_POST : ST_MARK;
				end
				ST_MARK: begin
					chk_en_q <= 1'b1;
					if (fin)
						state_q <= ST_POST;
				end
				ST_POST: begin
					// hand the result over once the output slot is free
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= res_alloc_q ?
							{{(bfa_pkg::M_DATA_W-bfa_pkg::FRAME_W){1'b0}},
							 base_q + bfa_pkg::FRAME_W'(found_q)} : '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
